@@ rtl/ucpb_pkg.sv @@
// ucpb_pkg: shared types and constants for the unique color palette builder
// used by ucpb_ctrl, ucpb_datapath and unique_color_palette_builder
`timescale 1ns / 1ps

package ucpb_pkg;

  localparam int MAX_ENTRIES_DEF = 128;

  // command codes on the input channel
  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // result status codes
  localparam logic [2:0] ST_INSERTED = 3'd0;
  localparam logic [2:0] ST_PRESENT  = 3'd1;
  localparam logic [2:0] ST_DROPPED  = 3'd2;
  localparam logic [2:0] ST_READ_OK  = 3'd3;
  localparam logic [2:0] ST_READ_BAD = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_START,
    S_SCAN,
    S_DONE
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic accept;
    logic rd_issue;
    logic start;
    logic scan;
    logic res_insert;
    logic res_present;
    logic res_drop;
    logic load_out;
  } ctrl_t;

  // status from datapath to controller
  typedef struct packed {
    logic is_read;
    logic full;
    logic pend;
    logic match;
    logic scan_end;
    logic out_busy;
  } dp_stat_t;

endpackage

@@ rtl/ucpb_ctrl.sv @@
// ucpb_ctrl: sequencing state machine for the palette builder
// depends on ucpb_pkg for the state, command and status types
`timescale 1ns / 1ps

module ucpb_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  ucpb_pkg::dp_stat_t stat,
  output ucpb_pkg::ctrl_t    ctl
);

  ucpb_pkg::state_t state;
  ucpb_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ucpb_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ucpb_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = stat.is_read ? ucpb_pkg::S_READ : ucpb_pkg::S_START;
        end
      end
      ucpb_pkg::S_READ:  state_next = ucpb_pkg::S_DONE;
      ucpb_pkg::S_START: state_next = ucpb_pkg::S_SCAN;
      ucpb_pkg::S_SCAN: begin
        if (stat.full || (stat.pend && stat.match) || (!stat.pend && stat.scan_end)) begin
          state_next = ucpb_pkg::S_DONE;
        end
      end
      ucpb_pkg::S_DONE: begin
        if (!stat.out_busy) begin
          state_next = ucpb_pkg::S_IDLE;
        end
      end
      default: state_next = ucpb_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ctl      = '0;
    in_stall = 1'b1;
    unique case (state)
      ucpb_pkg::S_IDLE: begin
        in_stall   = 1'b0;
        ctl.accept = in_valid;
      end
      ucpb_pkg::S_READ:  ctl.rd_issue = 1'b1;
      ucpb_pkg::S_START: ctl.start = 1'b1;
      ucpb_pkg::S_SCAN: begin
        priority if (stat.full) begin
          ctl.res_drop = 1'b1;
        end else if (stat.pend && stat.match) begin
          ctl.res_present = 1'b1;
        end else if (!stat.pend && stat.scan_end) begin
          ctl.res_insert = 1'b1;
        end else begin
          ctl.scan = 1'b1;
        end
      end
      ucpb_pkg::S_DONE: ctl.load_out = !stat.out_busy;
      default: ctl = '0;
    endcase
  end

endmodule

@@ rtl/ucpb_datapath.sv @@
// ucpb_datapath: color store, entry count, compare pipeline and result register
// depends on ucpb_pkg; driven by commands from ucpb_ctrl
`timescale 1ns / 1ps

module ucpb_datapath #(
  parameter int MAX_ENTRIES = ucpb_pkg::MAX_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  ucpb_pkg::ctrl_t    ctl,
  output ucpb_pkg::dp_stat_t stat,
  input  logic               cfg_valid,
  input  logic               cfg_data,
  input  logic               cmd,
  input  logic [31:0]        color,
  input  logic               last,
  input  logic [6:0]         read_index,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         status,
  output logic [6:0]         entry_index,
  output logic [7:0]         entries_held,
  output logic [6:0]         selected_index,
  output logic [31:0]        read_color
);

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int WW = (CW > 8) ? CW : 8;

  logic [31:0]   mem [MAX_ENTRIES];

  logic          cmd_q;
  logic [31:0]   color_q;
  logic          last_q;
  logic [6:0]    ridx_q;
  logic          include_transparent;
  logic [CW-1:0] count;
  logic          set_finished;
  logic [CW-1:0] scan_idx;
  logic          pend;
  logic [AW-1:0] pend_idx;
  logic [31:0]   rdata;
  logic [2:0]    res_status;
  logic [AW-1:0] res_idx;

  logic          issue_ok;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [31:0]   wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [WW-1:0] ridx_w;
  logic [WW-1:0] count_w;
  logic [WW-1:0] res_idx_w;
  logic          rd_ok;
  logic          res_any;

  assign issue_ok  = scan_idx < count;
  assign ridx_w    = WW'(ridx_q);
  assign count_w   = WW'(count);
  assign res_idx_w = WW'(res_idx);
  assign rd_ok     = ridx_w < count_w;
  assign res_any   = ctl.res_insert || ctl.res_present || ctl.res_drop;

  assign stat.is_read  = (cmd == ucpb_pkg::CMD_READ);
  assign stat.full     = (count == CW'(MAX_ENTRIES));
  assign stat.pend     = pend;
  assign stat.match    = (rdata == color_q);
  assign stat.scan_end = !issue_ok;
  assign stat.out_busy = out_valid && out_stall;

  // write port: transparent preload at slot 0 or append at the count
  assign wr_en   = (ctl.start && set_finished && include_transparent) || ctl.res_insert;
  assign wr_addr = ctl.res_insert ? count[AW-1:0] : '0;
  assign wr_data = ctl.res_insert ? color_q : 32'd0;
  assign rd_en   = ctl.rd_issue || (ctl.scan && issue_ok);
  assign rd_addr = ctl.rd_issue ? ridx_w[AW-1:0] : scan_idx[AW-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      include_transparent <= 1'b1;
      count               <= '0;
      set_finished        <= 1'b1;
      scan_idx            <= '0;
      pend                <= 1'b0;
      out_valid           <= 1'b0;
    end else begin
      if (cfg_valid) begin
        include_transparent <= cfg_data;
      end
      if (ctl.start) begin
        scan_idx <= '0;
        pend     <= 1'b0;
        if (set_finished) begin
          count        <= include_transparent ? CW'(1) : '0;
          set_finished <= 1'b0;
        end
      end
      // one read issued per cycle, compared against the stored color in the next cycle
      if (ctl.scan) begin
        pend <= issue_ok;
        if (issue_ok) begin
          scan_idx <= scan_idx + CW'(1);
        end
      end
      if (ctl.res_insert) begin
        count <= count + CW'(1);
      end
      if (res_any) begin
        pend <= 1'b0;
        if (last_q) begin
          set_finished <= 1'b1;
        end
      end
      if (ctl.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      cmd_q   <= cmd;
      color_q <= color;
      last_q  <= last;
      ridx_q  <= read_index;
    end
    if (ctl.scan) begin
      pend_idx <= scan_idx[AW-1:0];
    end
    if (ctl.res_insert) begin
      res_status <= ucpb_pkg::ST_INSERTED;
      res_idx    <= count[AW-1:0];
    end else if (ctl.res_present) begin
      res_status <= ucpb_pkg::ST_PRESENT;
      res_idx    <= pend_idx;
    end else if (ctl.res_drop) begin
      res_status <= ucpb_pkg::ST_DROPPED;
      res_idx    <= '0;
    end
    if (ctl.load_out) begin
      entries_held   <= count_w[7:0];
      selected_index <= (count >= CW'(2)) ? 7'd1 : 7'd0;
      if (cmd_q == ucpb_pkg::CMD_READ) begin
        status      <= rd_ok ? ucpb_pkg::ST_READ_OK : ucpb_pkg::ST_READ_BAD;
        entry_index <= 7'd0;
        read_color  <= rd_ok ? rdata : 32'd0;
      end else begin
        status      <= res_status;
        entry_index <= res_idx_w[6:0];
        read_color  <= 32'd0;
      end
    end
  end

  a_insert_not_full: assert property (@(posedge clk) disable iff (rst)
    ctl.res_insert |-> (count < CW'(MAX_ENTRIES)))
    else $error("insert with full palette");

  a_present_has_match: assert property (@(posedge clk) disable iff (rst)
    ctl.res_present |-> (pend && rdata == color_q))
    else $error("present reported without a matching entry");

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (rst)
    ctl.load_out |-> !(out_valid && out_stall))
    else $error("pending result overwritten");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    ctl.res_insert |=> (count <= CW'(MAX_ENTRIES) && count != '0))
    else $error("entry count out of range after insert");

endmodule

@@ rtl/unique_color_palette_builder.sv @@
// unique_color_palette_builder: top level joining controller and datapath
// depends on ucpb_pkg, ucpb_ctrl and ucpb_datapath
`timescale 1ns / 1ps
//
// Usage
// - input channel (in_valid/in_stall): cmd, color, last, read_index. cmd add
//   puts a color into the palette, cmd read returns one stored entry
// - output channel (out_valid/out_stall): one result per input item with
//   status, entry_index, entries_held, selected_index and read_color
// - config channel (cfg_valid/cfg_ready, always ready): cfg_data sets
//   include_transparent; write it only while the block is idle
// - one item is in work at a time. an add that inserts compares every stored
//   entry first, one that finds its color stops at the match; the compare is
//   done by the single color memory read port scanning one entry per cycle,
//   and a full palette drops the color without a scan
// - the first add after an add marked last starts a new palette, with slot 0
//   preloaded to transparent when include_transparent is set
// - reset clears the count, marks the set finished, sets include_transparent
//   and empties the output register; memory contents are not cleared
// - a stalled result holds in the output register; the next item may be
//   transferred meanwhile and waits for the register before its result lands
module unique_color_palette_builder #(
  parameter int MAX_ENTRIES = ucpb_pkg::MAX_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        cmd,
  input  logic [31:0] color,
  input  logic        last,
  input  logic [6:0]  read_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [6:0]  entry_index,
  output logic [7:0]  entries_held,
  output logic [6:0]  selected_index,
  output logic [31:0] read_color
);

  ucpb_pkg::ctrl_t    ctl;
  ucpb_pkg::dp_stat_t stat;

  assign cfg_ready = 1'b1;

  ucpb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .ctl      (ctl)
  );

  ucpb_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .ctl            (ctl),
    .stat           (stat),
    .cfg_valid      (cfg_valid),
    .cfg_data       (cfg_data),
    .cmd            (cmd),
    .color          (color),
    .last           (last),
    .read_index     (read_index),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .entry_index    (entry_index),
    .entries_held   (entries_held),
    .selected_index (selected_index),
    .read_color     (read_color)
  );

endmodule

@@ verif/tb.sv @@
// tb: self-checking testbench for unique_color_palette_builder
// depends on ucpb_pkg and the rtl top level; directed table plus random palette sets
`timescale 1ns / 1ps

module tb;

  localparam int PAL_DEPTH = ucpb_pkg::MAX_ENTRIES_DEF;
  localparam int RAND_ITEMS = 1400;
  localparam int RAND_PHASES = 4;
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES = 140;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int REPORT_MAX = 10;

  typedef struct packed {
    logic        cmd;
    logic [31:0] color;
    logic        last;
    logic [6:0]  rd_idx;
  } pal_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [6:0]  index;
    logic [7:0]  size;
    logic [6:0]  sel;
    logic [31:0] rcolor;
  } pal_result_t;

  typedef enum logic [1:0] {ROW_ITEM, ROW_FILL, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    int unsigned reps;
    logic        typed;
    pal_item_t   item;
    pal_result_t res;
  } stim_row_t;

  typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_BEAT} stall_mode_e;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_data = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        cmd = 1'b0;
  logic [31:0] color = '0;
  logic        last = 1'b0;
  logic [6:0]  read_index = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  status;
  logic [6:0]  entry_index;
  logic [7:0]  entries_held;
  logic [6:0]  selected_index;
  logic [31:0] read_color;

  unique_color_palette_builder dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .cmd            (cmd),
    .color          (color),
    .last           (last),
    .read_index     (read_index),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .entry_index    (entry_index),
    .entries_held   (entries_held),
    .selected_index (selected_index),
    .read_color     (read_color)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // palette predictor state
  logic [31:0] pal_store [PAL_DEPTH];
  int unsigned pal_count = 0;
  bit          set_done = 1'b1;
  bit          pal_transp = 1'b1;

  pal_result_t expected_q[$];
  stim_row_t   stim_rows[$];
  int          items_sent = 0;
  int          results_seen = 0;
  int          mismatches = 0;
  int          status_seen [8];
  int          burst_left = 0;
  int          cyc = 0;

  function automatic pal_result_t palette_predict(input pal_item_t it);
    pal_result_t r;
    bit          hit;
    int unsigned j;
    r = '0;
    hit = 1'b0;
    if (it.cmd == ucpb_pkg::CMD_READ) begin
      if (it.rd_idx < pal_count) begin
        r.status = ucpb_pkg::ST_READ_OK;
        r.rcolor = pal_store[it.rd_idx];
      end else begin
        r.status = ucpb_pkg::ST_READ_BAD;
      end
    end else begin
      // first add after a finished set opens a fresh palette
      if (set_done) begin
        pal_count = 0;
        if (pal_transp) begin
          pal_store[0] = '0;
          pal_count = 1;
        end
        set_done = 1'b0;
      end
      if (pal_count >= PAL_DEPTH) begin
        r.status = ucpb_pkg::ST_DROPPED;
      end else begin
        for (j = 0; j < pal_count && !hit; j++) begin
          if (pal_store[j] == it.color) begin
            hit = 1'b1;
            r.index = 7'(j);
          end
        end
        if (hit) begin
          r.status = ucpb_pkg::ST_PRESENT;
        end else begin
          r.index = 7'(pal_count);
          pal_store[pal_count] = it.color;
          pal_count++;
          r.status = ucpb_pkg::ST_INSERTED;
        end
      end
      if (it.last) set_done = 1'b1;
    end
    r.size = 8'(pal_count);
    r.sel = (pal_count >= 2) ? 7'd1 : 7'd0;
    return r;
  endfunction

  function automatic void add_row(input row_kind_e k, input int unsigned n, input logic typed,
                                  input pal_item_t it, input pal_result_t res);
    stim_row_t row;
    row.kind = k;
    row.reps = n;
    row.typed = typed;
    row.item = it;
    row.res = res;
    stim_rows.push_back(row);
  endfunction

  // called just after a rising edge; returns at the edge where the transfer happened
  task automatic send_item(input pal_item_t it, input logic typed, input pal_result_t res);
    pal_result_t pred;
    int          gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 20);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    cmd <= it.cmd;
    color <= it.color;
    last <= it.last;
    read_index <= it.rd_idx;
    do @(posedge clk); while (in_stall);
    pred = palette_predict(it);
    expected_q.push_back(typed ? res : pred);
    items_sent++;
  endtask

  task automatic drain_pending();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(input logic v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    pal_transp = v;
  endtask

  // receiver stall pattern, switching among none, light, heavy and beat modes at random
  stall_mode_e stall_mode = STALL_NONE;
  int          stall_left = 0;
  int          beat = 0;

  always @(posedge clk) begin
    beat <= beat + 1;
    if (stall_left == 0) begin
      stall_mode <= stall_mode_e'($urandom_range(0, 3));
      stall_left <= $urandom_range(32, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      case (stall_mode)
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        STALL_BEAT:  out_stall <= ((beat % 7) < 3);
        default:     out_stall <= 1'b0;
      endcase
    end
  end

  // result checker
  always @(posedge clk) begin
    pal_result_t got;
    pal_result_t exp_r;
    logic        bad;
    if (!rst && out_valid && !out_stall) begin
      got = {status, entry_index, entries_held, selected_index, read_color};
      results_seen++;
      status_seen[got.status]++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("result %0d with nothing pending: st=%0d idx=%0d size=%0d sel=%0d rd=%h",
                   results_seen, got.status, got.index, got.size, got.sel, got.rcolor);
      end else begin
        exp_r = expected_q.pop_front();
        bad = (got.status !== exp_r.status) || (got.index !== exp_r.index) ||
              (got.size !== exp_r.size) || (got.sel !== exp_r.sel) ||
              (got.rcolor !== exp_r.rcolor);
        if (bad) begin
          mismatches++;
          if (mismatches <= REPORT_MAX) begin
            $display("mismatch on result %0d", results_seen);
            $display("  expected st=%0d idx=%0d size=%0d sel=%0d rd=%h",
                     exp_r.status, exp_r.index, exp_r.size, exp_r.sel, exp_r.rcolor);
            $display("  actual   st=%0d idx=%0d size=%0d sel=%0d rd=%h",
                     got.status, got.index, got.size, got.sel, got.rcolor);
          end
        end
      end
    end
  end

  initial begin
    while (cyc < CYCLE_LIMIT) begin
      @(posedge clk);
      cyc++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    pal_item_t   it;
    int unsigned k;
    int unsigned n_adds;
    int unsigned lim;
    int unsigned pick;
    int unsigned dup_pct;
    int          phase_end;
    bit          big;

    // after reset, transparent preload on
    add_row(ROW_ITEM, 1, 1'b1, {ucpb_pkg::CMD_READ, 32'h0, 1'b0, 7'd0},
            {ucpb_pkg::ST_READ_BAD, 7'd0, 8'd0, 7'd0, 32'h0});
    add_row(ROW_ITEM, 1, 1'b1, {ucpb_pkg::CMD_READ, 32'h0, 1'b1, 7'd127},
            {ucpb_pkg::ST_READ_BAD, 7'd0, 8'd0, 7'd0, 32'h0});
    // transparent already sits in slot 0
    add_row(ROW_ITEM, 1, 1'b1, {ucpb_pkg::CMD_ADD, 32'h0, 1'b0, 7'd0},
            {ucpb_pkg::ST_PRESENT, 7'd0, 8'd1, 7'd0, 32'h0});
    add_row(ROW_ITEM, 1, 1'b1, {ucpb_pkg::CMD_ADD, 32'hFFFF_FFFF, 1'b0, 7'd127},
            {ucpb_pkg::ST_INSERTED, 7'd1, 8'd2, 7'd1, 32'h0});
    add_row(ROW_ITEM, 1, 1'b1, {ucpb_pkg::CMD_ADD, 32'h0000_00FF, 1'b0, 7'd0},
            {ucpb_pkg::ST_INSERTED, 7'd2, 8'd3, 7'd1, 32'h0});
    add_row(ROW_ITEM, 1, 1'b1, {ucpb_pkg::CMD_ADD, 32'hFF00_0000, 1'b0, 7'd0},
            {ucpb_pkg::ST_INSERTED, 7'd3, 8'd4, 7'd1, 32'h0});
    add_row(ROW_ITEM, 1, 1'b1, {ucpb_pkg::CMD_ADD, 32'hFFFF_FFFF, 1'b0, 7'd0},
            {ucpb_pkg::ST_PRESENT, 7'd1, 8'd4, 7'd1, 32'h0});
    add_row(ROW_ITEM, 1, 1'b1, {ucpb_pkg::CMD_READ, 32'hFFFF_FFFF, 1'b0, 7'd0},
            {ucpb_pkg::ST_READ_OK, 7'd0, 8'd4, 7'd1, 32'h0});
    // last on a read is ignored
    add_row(ROW_ITEM, 1, 1'b1, {ucpb_pkg::CMD_READ, 32'h0, 1'b1, 7'd1},
            {ucpb_pkg::ST_READ_OK, 7'd0, 8'd4, 7'd1, 32'hFFFF_FFFF});
    add_row(ROW_ITEM, 1, 1'b1, {ucpb_pkg::CMD_READ, 32'h0, 1'b0, 7'd4},
            {ucpb_pkg::ST_READ_BAD, 7'd0, 8'd4, 7'd1, 32'h0});
    add_row(ROW_ITEM, 1, 1'b1, {ucpb_pkg::CMD_ADD, 32'h1234_5678, 1'b1, 7'd0},
            {ucpb_pkg::ST_INSERTED, 7'd4, 8'd5, 7'd1, 32'h0});
    add_row(ROW_ITEM, 1, 1'b1, {ucpb_pkg::CMD_READ, 32'h0, 1'b0, 7'd4},
            {ucpb_pkg::ST_READ_OK, 7'd0, 8'd5, 7'd1, 32'h1234_5678});
    add_row(ROW_ITEM, 1, 1'b0, {ucpb_pkg::CMD_ADD, 32'hA5A5_A5A5, 1'b0, 7'd0}, '0);
    add_row(ROW_ITEM, 1, 1'b0, {ucpb_pkg::CMD_READ, 32'h0, 1'b0, 7'd2}, '0);
    add_row(ROW_ITEM, 1, 1'b0, {ucpb_pkg::CMD_ADD, 32'h5A5A_5A5A, 1'b1, 7'd0}, '0);
    // transparent preload off
    add_row(ROW_CFG, 1, 1'b0, {ucpb_pkg::CMD_ADD, 32'h0, 1'b0, 7'd0}, '0);
    add_row(ROW_ITEM, 1, 1'b1, {ucpb_pkg::CMD_ADD, 32'h0, 1'b0, 7'd0},
            {ucpb_pkg::ST_INSERTED, 7'd0, 8'd1, 7'd0, 32'h0});
    add_row(ROW_ITEM, 1, 1'b1, {ucpb_pkg::CMD_READ, 32'h0, 1'b0, 7'd0},
            {ucpb_pkg::ST_READ_OK, 7'd0, 8'd1, 7'd0, 32'h0});
    add_row(ROW_ITEM, 1, 1'b1, {ucpb_pkg::CMD_ADD, 32'h0, 1'b1, 7'd0},
            {ucpb_pkg::ST_PRESENT, 7'd0, 8'd1, 7'd0, 32'h0});
    add_row(ROW_ITEM, 1, 1'b1, {ucpb_pkg::CMD_ADD, 32'h8000_0001, 1'b1, 7'd0},
            {ucpb_pkg::ST_INSERTED, 7'd0, 8'd1, 7'd0, 32'h0});
    // fill the palette, then a present color is still dropped
    add_row(ROW_FILL, PAL_DEPTH, 1'b0, {ucpb_pkg::CMD_ADD, 32'hC0DE_0000, 1'b0, 7'd0}, '0);
    add_row(ROW_ITEM, 1, 1'b1, {ucpb_pkg::CMD_ADD, 32'hC0DE_0005, 1'b0, 7'd0},
            {ucpb_pkg::ST_DROPPED, 7'd0, 8'd128, 7'd1, 32'h0});
    add_row(ROW_ITEM, 1, 1'b1, {ucpb_pkg::CMD_READ, 32'h0, 1'b0, 7'd127},
            {ucpb_pkg::ST_READ_OK, 7'd0, 8'd128, 7'd1, 32'hC0DE_007F});
    add_row(ROW_ITEM, 1, 1'b1, {ucpb_pkg::CMD_ADD, 32'hFFFF_FFFF, 1'b1, 7'd0},
            {ucpb_pkg::ST_DROPPED, 7'd0, 8'd128, 7'd1, 32'h0});
    add_row(ROW_ITEM, 1, 1'b0, {ucpb_pkg::CMD_READ, 32'h0, 1'b1, 7'd127}, '0);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (stim_rows[r]) begin
      case (stim_rows[r].kind)
        ROW_CFG: begin
          drain_pending();
          write_cfg(stim_rows[r].item.color[0]);
        end
        ROW_FILL: begin
          for (k = 0; k < stim_rows[r].reps; k++) begin
            it = stim_rows[r].item;
            it.color = it.color + k;
            send_item(it, 1'b0, '0);
          end
        end
        default: send_item(stim_rows[r].item, stim_rows[r].typed, stim_rows[r].res);
      endcase
    end

    // random palette sets, alternating the transparent preload per phase
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      drain_pending();
      write_cfg(ph % 2 == 0);
      phase_end = items_sent + RAND_ITEMS / RAND_PHASES;
      while (items_sent < phase_end) begin
        big = ($urandom_range(0, 99) < 4);
        if (big) n_adds = $urandom_range(135, 150);
        else if ($urandom_range(0, 9) < 8) n_adds = $urandom_range(1, 24);
        else n_adds = $urandom_range(25, 80);
        dup_pct = big ? 5 : 40;
        for (k = 0; k < n_adds; k++) begin
          if ($urandom_range(0, 99) < 20) begin
            it.cmd = ucpb_pkg::CMD_READ;
            it.color = $urandom;
            it.last = 1'($urandom_range(0, 1));
            lim = (pal_count > 127) ? 127 : pal_count;
            if ($urandom_range(0, 9) < 7) it.rd_idx = 7'($urandom_range(0, lim));
            else it.rd_idx = 7'($urandom_range(0, 127));
            send_item(it, 1'b0, '0);
          end
          it.cmd = ucpb_pkg::CMD_ADD;
          it.rd_idx = 7'($urandom_range(0, 127));
          pick = $urandom_range(0, 99);
          if (!set_done && pal_count != 0 && pick < dup_pct)
            it.color = pal_store[$urandom_range(0, pal_count - 1)];
          else if (pick < dup_pct + 5) it.color = 32'h0;
          else if (pick < dup_pct + 8) it.color = 32'hFFFF_FFFF;
          else it.color = $urandom;
          // now and then a set runs on without its end mark, or ends early
          it.last = ((k == n_adds - 1) && ($urandom_range(0, 19) != 0)) ||
                    ($urandom_range(0, 99) == 0);
          send_item(it, 1'b0, '0);
        end
      end
    end

    drain_pending();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("%0d items sent, %0d results checked, %0d mismatches",
             items_sent, results_seen, mismatches);
    $display("inserted %0d, present %0d, dropped %0d, reads ok %0d, reads out of range %0d",
             status_seen[ucpb_pkg::ST_INSERTED], status_seen[ucpb_pkg::ST_PRESENT],
             status_seen[ucpb_pkg::ST_DROPPED], status_seen[ucpb_pkg::ST_READ_OK],
             status_seen[ucpb_pkg::ST_READ_BAD]);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
